### src/pac_pkg.sv
// Package for the pager alert controller: event and mode codes, register
// indexes, reset values and the result record type.
// No dependencies; used by pager_alert_controller_top.
`default_nettype none

package pac_pkg;

    typedef enum logic [2:0] {
        OP_RF_BYTE   = 3'd0,
        OP_LED_TICK  = 3'd1,
        OP_SOUND     = 3'd2,
        OP_RANGE     = 3'd3,
        OP_BATTERY   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_CALLED = 2'd1,
        MODE_AWAY   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_OWN_ID        = 2'd0,
        CFG_BATTERY_LIMIT = 2'd1,
        CFG_LED_DIVIDE    = 2'd2,
        CFG_RANGE_DIVIDE  = 2'd3
    } cfg_index_t;

    localparam logic [7:0] HDR_CALL  = 8'h2A;  // '*'
    localparam logic [7:0] HDR_CLEAR = 8'h23;  // '#'

    localparam logic [7:0] OWN_ID_RESET        = 8'd75;
    localparam logic [7:0] BATTERY_LIMIT_RESET = 8'd55;
    localparam logic [7:0] LED_DIVIDE_RESET    = 8'd8;
    localparam logic [7:0] RANGE_DIVIDE_RESET  = 8'd19;

    // Bit positions in the drive register.
    localparam int DRV_RED   = 0;
    localparam int DRV_GREEN = 1;
    localparam int DRV_VIB   = 2;
    localparam int DRV_BEEP  = 3;

    typedef struct packed {
        logic       red_on;
        logic       green_on;
        logic [3:0] cathodes;
        logic       vibrate;
        logic       beep;
        mode_t      mode;
        logic       battery_empty;
        logic       adc_start;
    } result_t;

endpackage

`default_nettype wire

### src/pager_alert_controller_top.sv
// Pager alert controller top level: event decoding, pager state and a
// two-entry result queue. Depends on pac_pkg.
//
// Usage:
// The input channel (in_valid / in_stall) carries one event per transfer:
// operation selects an RF byte, LED tick, sound tick, range tick or battery
// sample, and value holds the RF byte or the ADC high byte.
// Every event yields exactly one result transfer on the output channel
// (out_valid / out_stall) with the LED, buzzer and vibrator drives, the
// pager mode, the battery flag and a one-result ADC start pulse.
// The state update is done in the cycle of the input transfer, and its result
// is registered into the result queue. One event per cycle is taken while
// the queue is not full; the state update itself is combinational.
// Results wait in a two-entry queue, so the next event is taken while one
// result is still stalled; in_stall rises only when both entries are full.
// Configuration writes (cfg_valid / cfg_ready, always ready) set the own id,
// the battery limit and the two dividers; they are to be made only while
// idle, which the user must ensure: the block does not enforce it. Reset
// clears the pager state, loads the defaults and empties the result queue.
`default_nettype none

module pager_alert_controller_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [2:0]             operation,
    input  wire logic [7:0]             value,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        red_on,
    output logic                        green_on,
    output logic [3:0]                  cathodes,
    output logic                        vibrate,
    output logic                        beep,
    output logic [1:0]                  mode,
    output logic                        battery_empty,
    output logic                        adc_start
);

    import pac_pkg::*;

    localparam logic [1:0] QUEUE_FULL = 2'd2;

    logic [7:0] own_id_reg, battery_limit_reg, led_divide_reg, range_divide_reg;

    mode_t      mode_reg,        mode_next;
    logic       low_battery_reg, low_battery_next;
    logic [7:0] header_reg,      header_next;
    logic [7:0] range_mark_reg,  range_mark_next;
    logic [7:0] phase_reg,       phase_next;
    logic [7:0] led_count_reg,   led_count_next;
    logic [7:0] range_count_reg, range_count_next;
    logic [1:0] beat_reg,        beat_next;
    logic [3:0] cathode_reg,     cathode_next;
    logic [3:0] drive_reg,       drive_next;
    logic       adc_next;

    result_t    queue_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg,  count_next;
    result_t    result_next;

    logic       in_fire, out_fire;

    // Walk the single lit (low) cathode one position up.
    function automatic logic [3:0] rotate_cathodes(input logic [3:0] c);
        logic [3:0] r;
        r = c;
        if (!c[0]) begin
            r[0] = 1'b1; r[1] = 1'b0;
        end else if (!c[1]) begin
            r[1] = 1'b1; r[2] = 1'b0;
        end else if (!c[2]) begin
            r[2] = 1'b1; r[3] = 1'b0;
        end else begin
            r[3] = 1'b1; r[0] = 1'b0;
        end
        return r;
    endfunction

    assign in_stall  = (count_reg == QUEUE_FULL);
    assign out_valid = (count_reg != 2'd0);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg        <= OWN_ID_RESET;
            battery_limit_reg <= BATTERY_LIMIT_RESET;
            led_divide_reg    <= LED_DIVIDE_RESET;
            range_divide_reg  <= RANGE_DIVIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_OWN_ID:        own_id_reg        <= cfg_data;
                CFG_BATTERY_LIMIT: battery_limit_reg <= cfg_data;
                CFG_LED_DIVIDE:    led_divide_reg    <= cfg_data;
                CFG_RANGE_DIVIDE:  range_divide_reg  <= cfg_data;
                default:           own_id_reg        <= own_id_reg;
            endcase
        end
    end

    always_comb
    begin
        logic  [7:0] count_inc;
        mode_t       mode_mid;
        logic  [1:0] beat_inc;

        mode_next        = mode_reg;
        low_battery_next = low_battery_reg;
        header_next      = header_reg;
        range_mark_next  = range_mark_reg;
        phase_next       = phase_reg;
        led_count_next   = led_count_reg;
        range_count_next = range_count_reg;
        beat_next        = beat_reg;
        cathode_next     = cathode_reg;
        drive_next       = drive_reg;
        adc_next         = 1'b0;
        count_inc        = 8'd0;
        mode_mid         = mode_reg;
        beat_inc         = 2'd0;

        case (op_t'(operation))
            OP_RF_BYTE:
            begin
                if (value == HDR_CALL || value == HDR_CLEAR)
                begin
                    header_next     = value;
                    range_mark_next = value;
                    if (mode_reg == MODE_AWAY)
                    begin
                        mode_next            = MODE_WAIT;
                        drive_next[DRV_RED]   = 1'b0;
                        drive_next[DRV_GREEN] = 1'b0;
                        drive_next[DRV_VIB]   = 1'b0;
                    end
                end
                else if (value == own_id_reg)
                begin
                    // The call test runs first; the clear test sees its outcome.
                    if ((header_reg == HDR_CALL && mode_reg == MODE_WAIT) ||
                        mode_reg == MODE_AWAY)
                        mode_mid = MODE_CALLED;
                    mode_next = mode_mid;
                    if ((header_reg == HDR_CLEAR && mode_mid == MODE_CALLED) ||
                        mode_mid == MODE_AWAY)
                    begin
                        mode_next            = MODE_WAIT;
                        drive_next[DRV_RED]   = 1'b0;
                        drive_next[DRV_GREEN] = 1'b0;
                        drive_next[DRV_VIB]   = 1'b0;
                    end
                    header_next = 8'd0;
                end
            end
            OP_LED_TICK:
            begin
                if (mode_reg != MODE_WAIT && !low_battery_reg)
                begin
                    count_inc      = led_count_reg + 8'd1;
                    led_count_next = count_inc;
                    if (count_inc == led_divide_reg)
                    begin
                        phase_next     = phase_reg + 8'd1;
                        led_count_next = 8'd0;
                        if (mode_reg == MODE_CALLED)
                        begin
                            drive_next[DRV_RED]   = 1'b0;
                            drive_next[DRV_GREEN] = 1'b1;
                        end
                        else if (mode_reg == MODE_AWAY)
                        begin
                            drive_next[DRV_RED]   = 1'b1;
                            drive_next[DRV_GREEN] = 1'b0;
                        end
                        cathode_next = rotate_cathodes(cathode_reg);
                    end
                end
            end
            OP_SOUND:
            begin
                if (mode_reg == MODE_CALLED || (mode_reg == MODE_AWAY && !low_battery_reg))
                begin
                    if (phase_reg < 8'd2)
                    begin
                        beat_inc            = beat_reg + 2'd1;
                        beat_next           = beat_inc;
                        drive_next[DRV_VIB] = 1'b0;
                        if (beat_inc == 2'd1)
                            drive_next[DRV_BEEP] = 1'b1;
                        if (beat_inc == 2'd2)
                        begin
                            beat_next            = 2'd0;
                            drive_next[DRV_BEEP] = 1'b0;
                        end
                    end
                    else if (phase_reg < 8'd4)
                        drive_next[DRV_VIB] = 1'b1;
                    else
                        phase_next = 8'd0;
                end
            end
            OP_RANGE:
            begin
                count_inc        = range_count_reg + 8'd1;
                range_count_next = count_inc;
                if (count_inc == range_divide_reg)
                begin
                    if (range_mark_reg == 8'd0)
                        mode_next = MODE_AWAY;
                    else
                        range_mark_next = 8'd0;
                    range_count_next = 8'd0;
                    adc_next         = 1'b1;
                end
            end
            OP_BATTERY:
            begin
                if (value > battery_limit_reg)
                begin
                    low_battery_next      = 1'b1;
                    drive_next[DRV_RED]   = 1'b1;
                    drive_next[DRV_GREEN] = 1'b0;
                    cathode_next          = 4'h0;
                end
                else
                begin
                    if (low_battery_reg)
                    begin
                        cathode_next          = 4'hF;
                        drive_next[DRV_RED]   = 1'b0;
                        drive_next[DRV_GREEN] = 1'b0;
                    end
                    low_battery_next = 1'b0;
                end
            end
            default:
            begin
                adc_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_next.red_on        = drive_next[DRV_RED];
        result_next.green_on      = drive_next[DRV_GREEN];
        result_next.cathodes      = cathode_next;
        result_next.vibrate       = drive_next[DRV_VIB];
        result_next.beep          = drive_next[DRV_BEEP];
        result_next.mode          = mode_next;
        result_next.battery_empty = low_battery_next;
        result_next.adc_start     = adc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_WAIT;
            low_battery_reg <= 1'b0;
            header_reg      <= 8'd0;
            range_mark_reg  <= 8'd0;
            phase_reg       <= 8'd0;
            led_count_reg   <= 8'd0;
            range_count_reg <= 8'd0;
            beat_reg        <= 2'd0;
            cathode_reg     <= 4'hF;
            drive_reg       <= 4'h0;
        end
        else if (in_fire)
        begin
            mode_reg        <= mode_next;
            low_battery_reg <= low_battery_next;
            header_reg      <= header_next;
            range_mark_reg  <= range_mark_next;
            phase_reg       <= phase_next;
            led_count_reg   <= led_count_next;
            range_count_reg <= range_count_next;
            beat_reg        <= beat_next;
            cathode_reg     <= cathode_next;
            drive_reg       <= drive_next;
        end
    end

    // Result queue: written on an input transfer, read on an output transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            queue_mem[wr_ptr_reg] <= result_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_fire && !out_fire)
            count_next = count_reg + 2'd1;
        else if (!in_fire && out_fire)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (in_fire)
                wr_ptr_reg <= !wr_ptr_reg;
            if (out_fire)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign red_on        = queue_mem[rd_ptr_reg].red_on;
    assign green_on      = queue_mem[rd_ptr_reg].green_on;
    assign cathodes      = queue_mem[rd_ptr_reg].cathodes;
    assign vibrate       = queue_mem[rd_ptr_reg].vibrate;
    assign beep          = queue_mem[rd_ptr_reg].beep;
    assign mode          = queue_mem[rd_ptr_reg].mode;
    assign battery_empty = queue_mem[rd_ptr_reg].battery_empty;
    assign adc_start     = queue_mem[rd_ptr_reg].adc_start;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_fire) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("result queue lost an entry");

    a_low_batt_dark: assert property (@(posedge clk) disable iff (!rst_n)
        low_battery_reg |-> (cathode_reg == 4'h0))
        else $error("cathodes lit during low battery");

    a_batt_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op_t'(operation) == OP_BATTERY && value > battery_limit_reg)
        |=> low_battery_reg)
        else $error("battery sample above limit did not set low battery");

endmodule

`default_nettype wire
